@@ hdl/spq_pkg.sv @@
// Shared types and constants for the stable minimum priority queue.
// No dependencies; every other file imports this package.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int PRIO_W   = 16;
  localparam int ECNT_W   = 5;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
  } slot_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic ins;        // insert request this cycle
    logic rem;        // remove head this cycle
    logic occ;        // cell holds a live entry
    logic left_keep;  // left neighbor keeps its entry (tied high at the head)
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts it on insert/remove.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  slot_t      new_slot,
  input  slot_t      left_slot,
  input  slot_t      right_slot,
  output slot_t      slot,
  output logic       keep
);

  slot_t slot_r;
  slot_t slot_nxt;

  // Stay put when live and not later in order than the new entry (ties stay ahead).
  assign keep = ctrl.occ && (slot_r.prio <= new_slot.prio);
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.ins) begin
      if (!keep) begin
        slot_nxt = ctrl.left_keep ? new_slot : left_slot;
      end
    end else if (ctrl.rem) begin
      slot_nxt = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/stable_min_priority_queue_core.sv @@
// Top level of the stable minimum priority queue: chain of spq_cell slots,
// fill counter and registered result. Depends on spq_pkg and spq_cell.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | action, item_value, item_priority
//   out     | output    | out_valid/out_stall| value, status, is_empty, is_full, count
//
// One request per cycle unless stalled: all slots compare and shift in the same cycle.
// The result appears in the output register in the cycle after acceptance.
// in_stall is high only while a result is held and out_stall is high.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
`default_nettype none

module stable_min_priority_queue_core import spq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [VAL_W-1:0]  in_item_value,
  input  logic [PRIO_W-1:0]        in_item_priority,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_value,
  output logic [1:0]               out_status,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  output logic [ECNT_W-1:0]        out_entry_count
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  status_t          status_r, status_nxt;

  logic  accept, empty, full, do_ins, do_rem;
  slot_t new_slot;
  slot_t slots [CAPACITY];
  logic  keeps [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign empty    = (count_r == '0);
  assign full     = (count_r >= CNT_W'(CAPACITY));
  assign do_ins   = accept && (in_action == ACT_ENQ) && !full;
  assign do_rem   = accept && (in_action == ACT_DEQ) && !empty;

  assign new_slot.value = in_item_value;
  assign new_slot.prio  = in_item_priority;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t ctrl;
    slot_t      left_s, right_s;

    assign ctrl.ins       = do_ins;
    assign ctrl.rem       = do_rem;
    assign ctrl.occ       = (count_r > CNT_W'(i));
    assign ctrl.left_keep = (i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i-1];
    assign left_s  = slots[(i == 0) ? 0 : i-1];
    assign right_s = slots[(i == CAPACITY-1) ? i : i+1];

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_slot   (new_slot),
      .left_slot  (left_s),
      .right_slot (right_s),
      .slot       (slots[i]),
      .keep       (keeps[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    value_nxt  = '0;
    status_nxt = ST_OK;
    unique case (in_action)
      ACT_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          value_nxt = slots[0].value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = value_r;
  assign out_status      = status_r;
  // Count register already holds the level after the request in the output register.
  assign out_is_empty    = (count_r == '0);
  assign out_is_full     = (count_r >= CNT_W'(CAPACITY));
  assign out_entry_count = ECNT_W'(count_r);

endmodule

`default_nettype wire

@@ hdl/spq_checker.sv @@
// Port-level checker for stable_min_priority_queue_core, attached by bind.
// Depends on spq_pkg.
`default_nettype none

module spq_checker import spq_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_value,
  input logic [1:0]              out_status,
  input logic                    out_is_empty,
  input logic                    out_is_full,
  input logic [ECNT_W-1:0]       out_entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)) && !(out_is_empty && out_is_full))
    else $error("empty flag disagrees with count");

  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_value == '0) && out_is_empty)
    else $error("failed dequeue reports wrong state");

  a_enq_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_value == '0) && out_is_full)
    else $error("dropped enqueue reports wrong state");

endmodule

bind stable_min_priority_queue_core spq_checker u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value       (out_value),
  .out_status      (out_status),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full),
  .out_entry_count (out_entry_count)
);

`default_nettype wire
